// ===== hdl/swsc_pkg.sv =====
package swsc_pkg;

  // request codes on the input channel
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;
  localparam logic [1:0] REQ_INIT   = 2'd3;

  // classified operations handed to the engine
  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_SAMPLE = 3'd1;
  localparam logic [2:0] OP_QUERY  = 3'd2;
  localparam logic [2:0] OP_LOAD   = 3'd3;
  localparam logic [2:0] OP_INIT   = 3'd4;

  localparam int POS_W   = 13;
  localparam int SLOT_W  = 4;
  localparam int SHARE_W = 10;
  localparam int CFG_W   = 5;
  localparam int OSPAN_W = 4;
  localparam int OHITS_W = 9;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  typedef struct packed {
    logic [2:0]         op;
    logic [POS_W-1:0]   position;
    logic [SLOT_W-1:0]  slot;
    logic [POS_W-1:0]   span_begin;
    logic [POS_W-1:0]   span_end;
    logic [SHARE_W-1:0] span_share;
  } cmd_t;

endpackage

// ===== hdl/sliding_window_span_coverage_top.sv =====
// an item passes the input stage register and the queue, then the engine:
//   a sample scans spans one entry per cycle until one holds its position, a query
//   with a full ring makes one ratio compare per cycle, and loads, initializes and
//   ignored items go straight to the result register; one item per engine run
// reset: rst_n synchronous active low; clears handshakes, hit counts, ring index and
//   ready, spans_in_use returns to 1; span table and sample ring hold until written
module sliding_window_span_coverage_top
  import swsc_pkg::*;
#(
  parameter int WINDOW    = 256,
  parameter int MAX_SPANS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic               in_laser_on,
  input  logic [POS_W-1:0]   in_position,
  input  logic [SLOT_W-1:0]  in_span_slot,
  input  logic [POS_W-1:0]   in_span_begin,
  input  logic [POS_W-1:0]   in_span_end,
  input  logic [SHARE_W-1:0] in_span_share,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ready_res,
  output logic               out_choice_valid,
  output logic [OSPAN_W-1:0] out_chosen_span,
  output logic [OHITS_W-1:0] out_chosen_hits
);

  // span count register, clamped inside the engine
  logic [CFG_W-1:0] spans_in_use_r;

  // front to queue transfer
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // queue to engine transfer
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spans_in_use_r <= CFG_W'(1);
    end else if (cfg_we) begin
      spans_in_use_r <= cfg_wdata;
    end
  end

  // front: takes a transfer, turns laser-off samples and out-of-range loads into no-ops
  swsc_front #(
    .MAX_SPANS (MAX_SPANS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_laser_on   (in_laser_on),
    .in_position   (in_position),
    .in_span_slot  (in_span_slot),
    .in_span_begin (in_span_begin),
    .in_span_end   (in_span_end),
    .in_span_share (in_span_share),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  // two-entry queue decouples the front from the engine
  swsc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // engine: span table, hit counts, sample ring, query scan, output register
  swsc_back #(
    .WINDOW    (WINDOW),
    .MAX_SPANS (MAX_SPANS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .spans_in_use     (spans_in_use_r),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ready_res    (out_ready_res),
    .out_choice_valid (out_choice_valid),
    .out_chosen_span  (out_chosen_span),
    .out_chosen_hits  (out_chosen_hits)
  );

endmodule

// ===== hdl/swsc_front.sv =====
module swsc_front
  import swsc_pkg::*;
#(
  parameter int MAX_SPANS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic               in_laser_on,
  input  logic [POS_W-1:0]   in_position,
  input  logic [SLOT_W-1:0]  in_span_slot,
  input  logic [POS_W-1:0]   in_span_begin,
  input  logic [POS_W-1:0]   in_span_end,
  input  logic [SHARE_W-1:0] in_span_share,
  output logic               push,
  output cmd_t               push_cmd,
  input  logic               q_full
);

  logic stage_valid_r, stage_valid_nxt;
  cmd_t stage_r;
  cmd_t cls;
  logic accept;

  // classify: turn laser-off samples and loads to slots that do not exist into no-ops
  always_comb begin
    cls.position   = in_position;
    cls.slot       = in_span_slot;
    cls.span_begin = in_span_begin;
    cls.span_end   = in_span_end;
    cls.span_share = in_span_share;
    case (in_req_type)
      REQ_SAMPLE: cls.op = in_laser_on ? OP_SAMPLE : OP_NOP;
      REQ_QUERY:  cls.op = OP_QUERY;
      REQ_LOAD:   cls.op = (int'(in_span_slot) < MAX_SPANS) ? OP_LOAD : OP_NOP;
      REQ_INIT:   cls.op = OP_INIT;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign in_stall = stage_valid_r & q_full;
  assign accept   = in_valid & ~in_stall;
  assign push     = stage_valid_r & ~q_full;
  assign push_cmd = stage_r;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (push) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= cls;
    end
  end

endmodule

// ===== hdl/swsc_queue.sv =====
module swsc_queue
  import swsc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic q_full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  assign q_full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/swsc_back.sv =====
module swsc_back
  import swsc_pkg::*;
#(
  parameter int WINDOW    = 256,
  parameter int MAX_SPANS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CFG_W-1:0]   spans_in_use,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ready_res,
  output logic               out_choice_valid,
  output logic [OSPAN_W-1:0] out_chosen_span,
  output logic [OHITS_W-1:0] out_chosen_hits
);

  localparam int SW = $clog2(MAX_SPANS);
  localparam int RW = $clog2(WINDOW);
  localparam int HW = $clog2(WINDOW + 1);
  localparam int PW = HW + SHARE_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIND  = 3'd1;
  localparam logic [2:0] ST_DEC   = 3'd2;
  localparam logic [2:0] ST_INC   = 3'd3;
  localparam logic [2:0] ST_QSCAN = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  cmd_t               cmd_r;
  logic [SW-1:0]      k_r;
  logic [SW-1:0]      sp_r;
  logic [SW-1:0]      last_idx;

  // span table, written by loads only
  logic [POS_W-1:0]   span_lo_r [MAX_SPANS];
  logic [POS_W-1:0]   span_hi_r [MAX_SPANS];
  logic [SHARE_W-1:0] permil_r  [MAX_SPANS];

  logic [HW-1:0]      hits_r [MAX_SPANS];
  logic [SW-1:0]      hit_addr;
  logic [HW-1:0]      hit_rd;

  // sample ring
  logic [SW-1:0]      ring_mem [WINDOW];
  logic [SW-1:0]      ring_q_r;
  logic [RW-1:0]      ring_idx_r;
  logic               ring_full_r;
  logic               ring_we;

  logic               found_r;
  logic [SW-1:0]      best_idx_r;
  logic [HW-1:0]      best_hits_r;
  logic [SHARE_W-1:0] best_perm_r;

  logic               out_valid_r;
  logic               out_ready_r;
  logic               out_choice_r;
  logic [OSPAN_W-1:0] out_span_r;
  logic [OHITS_W-1:0] out_hits_r;

  logic               in_span;
  logic               scan_last;
  logic [SHARE_W-1:0] perm_k;
  logic [PW-1:0]      lhs;
  logic [PW-1:0]      rhs;
  logic               take_k;
  logic               out_free;
  logic               dec_we;
  logic               inc_we;
  logic               clr_all;

  // clamp the span count to 1..MAX_SPANS, as a last scan index
  always_comb begin
    if (spans_in_use == '0) begin
      last_idx = '0;
    end else if (int'(spans_in_use) > MAX_SPANS) begin
      last_idx = SW'(MAX_SPANS - 1);
    end else begin
      last_idx = SW'(spans_in_use - 1'b1);
    end
  end

  assign scan_last = (k_r == last_idx);
  assign in_span   = (span_lo_r[k_r] <= cmd_r.position) && (cmd_r.position <= span_hi_r[k_r]);

  always_comb begin
    case (state_r)
      ST_DEC:  hit_addr = ring_q_r;
      ST_INC:  hit_addr = sp_r;
      default: hit_addr = k_r;
    endcase
  end
  assign hit_rd = hits_r[hit_addr];

  // cross-multiplied ratio compare, lower index wins ties
  assign perm_k = permil_r[k_r];
  assign lhs    = PW'(hit_rd) * PW'(best_perm_r);
  assign rhs    = PW'(best_hits_r) * PW'(perm_k);
  assign take_k = (perm_k != '0) && (!found_r || (lhs < rhs));

  assign out_free = ~out_valid_r | ~out_stall;
  assign pop      = (state_r == ST_IDLE) & q_valid;
  assign dec_we   = (state_r == ST_DEC) & ring_full_r & (hit_rd != '0);
  assign inc_we   = (state_r == ST_INC) & (hit_rd < HW'(WINDOW));
  assign ring_we  = (state_r == ST_DEC);
  assign clr_all  = pop & (q_cmd.op == OP_INIT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_SAMPLE: state_nxt = ST_FIND;
            OP_QUERY:  state_nxt = ring_full_r ? ST_QSCAN : ST_RESP;
            default:   state_nxt = ST_RESP;
          endcase
        end
      end
      ST_FIND: begin
        if (in_span) begin
          state_nxt = ST_DEC;
        end else if (scan_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_DEC:   state_nxt = ST_INC;
      ST_INC:   state_nxt = ST_RESP;
      ST_QSCAN: begin
        if (scan_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ring_idx_r  <= '0;
      ring_full_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_all) begin
        ring_idx_r  <= '0;
        ring_full_r <= 1'b0;
      end else if (state_r == ST_INC) begin
        if (ring_idx_r == RW'(WINDOW - 1)) begin
          ring_idx_r  <= '0;
          ring_full_r <= 1'b1;
        end else begin
          ring_idx_r <= ring_idx_r + 1'b1;
        end
      end
      if (state_r == ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan and result working registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r   <= q_cmd;
      k_r     <= '0;
      found_r <= 1'b0;
    end else if (state_r == ST_FIND || state_r == ST_QSCAN) begin
      k_r <= k_r + 1'b1;
    end
    if (state_r == ST_FIND && in_span) begin
      sp_r <= k_r;
    end
    if (state_r == ST_QSCAN && take_k) begin
      found_r     <= 1'b1;
      best_idx_r  <= k_r;
      best_hits_r <= hit_rd;
      best_perm_r <= perm_k;
    end
    if (state_r == ST_RESP && out_free) begin
      out_ready_r  <= ring_full_r;
      out_choice_r <= (cmd_r.op == OP_QUERY) & found_r;
      if ((cmd_r.op == OP_QUERY) && found_r) begin
        out_span_r <= OSPAN_W'(best_idx_r);
        out_hits_r <= OHITS_W'(best_hits_r);
      end else begin
        out_span_r <= '0;
        out_hits_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.op == OP_LOAD) begin
      span_lo_r[SW'(q_cmd.slot)] <= q_cmd.span_begin;
      span_hi_r[SW'(q_cmd.slot)] <= q_cmd.span_end;
      permil_r[SW'(q_cmd.slot)]  <= q_cmd.span_share;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      for (int i = 0; i < MAX_SPANS; i++) begin
        hits_r[i] <= '0;
      end
    end else begin
      if (dec_we) begin
        hits_r[ring_q_r] <= hit_rd - 1'b1;
      end
      if (inc_we) begin
        hits_r[sp_r] <= hit_rd + 1'b1;
      end
    end
  end

  // ring memory, read-first, registered read at the current ring index
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_idx_r] <= sp_r;
    end
    ring_q_r <= ring_mem[ring_idx_r];
  end

  assign out_valid        = out_valid_r;
  assign out_ready_res    = out_ready_r;
  assign out_choice_valid = out_choice_r;
  assign out_chosen_span  = out_span_r;
  assign out_chosen_hits  = out_hits_r;

endmodule
